// File: hdl/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg: shared definitions for the rational arithmetic unit
// Field widths, action codes, sequencer states and the divider status bundle.
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam int OPERAND_BITS_DEF = 16;
  localparam int ACTION_W         = 3;
  localparam int RES_NUM_W        = 33;
  localparam int RES_DEN_W        = 32;

  localparam logic [ACTION_W-1:0] ACT_ADD  = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_SUB  = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_MUL  = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_DIV  = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_SIMP = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_GCD,
    ST_CHK,
    ST_DIVN,
    ST_DIVD,
    ST_OUT
  } rau_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// File: hdl/rational_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// rational_arithmetic_unit: add, subtract, multiply, divide and simplify
// of signed fractions
// Cross products for the four arithmetic actions, binary GCD plus two exact
// divisions for simplify, all under one small sequencer.
// ----------------------------------------------------------------------------
// One transaction in gives exactly one transaction out. Add, subtract,
// multiply and divide run the one shared signed multiplier three times
// (a_num*b_den or a_num*b_num, a_den*b_num, a_den*b_den or a_den*b_num)
// and form the unreduced numerator and denominator; such a transaction
// steps through ST_MUL0, ST_MUL1, ST_MUL2 and ST_OUT, and the next one is
// taken once the sequencer is back in ST_IDLE. Simplify runs a binary
// (shift and subtract) GCD on the magnitudes of A, one step per cycle,
// then divides both magnitudes by the GCD in the restoring divider, one
// after the other. When A is 0 over 0 the result is 0 over 0. Codes 5 to
// 7 give 0 over 0. zero_den is 1 whenever the 32-bit result denominator
// is zero. in_stall is high from acceptance until the result is loaded
// into the output register; a result waiting there does not block the
// next input transaction.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit
  import rau_pkg::*;
#(
  parameter int OPERAND_BITS = OPERAND_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [ACTION_W-1:0]            action,
  input  logic signed [OPERAND_BITS-1:0] a_num,
  input  logic signed [OPERAND_BITS-1:0] a_den,
  input  logic signed [OPERAND_BITS-1:0] b_num,
  input  logic signed [OPERAND_BITS-1:0] b_den,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [RES_NUM_W-1:0]    res_num,
  output logic signed [RES_DEN_W-1:0]    res_den,
  output logic                           zero_den
);

  localparam int N     = OPERAND_BITS;
  localparam int PW    = 2 * N;          // product width
  localparam int SW    = PW + 1;         // sum of two products
  localparam int WIDE  = SW + RES_NUM_W; // room to sign-extend before truncating
  localparam int K_W   = $clog2(N);

  // Sequencer state
  rau_state_t state, state_next;

  // Operand registers
  logic [ACTION_W-1:0] act;
  logic signed [N-1:0] an, ad, bn, bd;

  // Multiplier
  logic signed [N-1:0]  mul_a, mul_b;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] p0, p1, p2;

  // GCD
  logic [N-1:0]   gx, gy, gcd_val, gsel;
  logic [K_W-1:0] k;
  logic           gcd_done;

  // Divider
  logic           div_start;
  logic [N-1:0]   div_dividend;
  logic [N-1:0]   div_quotient;
  div_status_t    div_stat;
  logic [N-1:0]   qn, qd;

  // Magnitudes
  logic [N-1:0] in_mag_num, in_mag_den, mag_an, mag_ad;

  // Result assembly
  logic signed [SW-1:0]   sum_add, sum_sub;
  logic signed [N:0]      simp_num, simp_den;
  logic signed [WIDE-1:0] num_wide, den_wide;
  logic                   accept, out_free;

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != ST_IDLE);

  // two's complement magnitude; the most negative value maps onto 2^(N-1)
  assign in_mag_num = a_num[N-1] ? (~a_num + 1'b1) : a_num;
  assign in_mag_den = a_den[N-1] ? (~a_den + 1'b1) : a_den;
  assign mag_an     = an[N-1] ? (~an + 1'b1) : an;
  assign mag_ad     = ad[N-1] ? (~ad + 1'b1) : ad;

  assign gcd_done = (gx == '0) || (gy == '0);
  assign gsel     = (gx == '0) ? gy : gx;

  // Multiplier operand select: three products in a fixed order
  always_comb begin
    mul_a = an;
    mul_b = bd;
    case (state)
      ST_MUL0: begin
        mul_a = an;
        mul_b = (act == ACT_MUL) ? bn : bd;
      end
      ST_MUL1: begin
        mul_a = ad;
        mul_b = bn;
      end
      ST_MUL2: begin
        mul_a = ad;
        mul_b = (act == ACT_DIV) ? bn : bd;
      end
      default: begin
        mul_a = an;
        mul_b = bd;
      end
    endcase
  end

  assign prod = PW'(mul_a) * PW'(mul_b);

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and divider control
  always_comb begin
    state_next   = state;
    div_start    = 1'b0;
    div_dividend = mag_an;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (action) inside
            ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV: state_next = ST_MUL0;
            ACT_SIMP:                           state_next = ST_GCD;
            default:                            state_next = ST_OUT;
          endcase
        end
      end
      ST_MUL0: state_next = ST_MUL1;
      ST_MUL1: state_next = ST_MUL2;
      ST_MUL2: state_next = ST_OUT;
      ST_GCD: begin
        if (gcd_done) begin
          state_next = ST_CHK;
        end
      end
      ST_CHK: begin
        if (gcd_val == '0) begin
          state_next = ST_OUT;
        end else begin
          div_start    = 1'b1;
          div_dividend = mag_an;
          state_next   = ST_DIVN;
        end
      end
      ST_DIVN: begin
        if (div_stat.done) begin
          div_start    = 1'b1;
          div_dividend = mag_ad;
          state_next   = ST_DIVD;
        end
      end
      ST_DIVD: begin
        if (div_stat.done) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          act <= action;
          an  <= a_num;
          ad  <= a_den;
          bn  <= b_num;
          bd  <= b_den;
          gx  <= in_mag_num;
          gy  <= in_mag_den;
          k   <= '0;
        end
      end
      ST_MUL0: p0 <= prod;
      ST_MUL1: p1 <= prod;
      ST_MUL2: p2 <= prod;
      ST_GCD: begin
        // binary GCD: strip common twos, strip lone twos, subtract odds
        if (gcd_done) begin
          gcd_val <= gsel << k;
        end else if (!gx[0] && !gy[0]) begin
          gx <= gx >> 1;
          gy <= gy >> 1;
          k  <= k + 1'b1;
        end else if (!gx[0]) begin
          gx <= gx >> 1;
        end else if (!gy[0]) begin
          gy <= gy >> 1;
        end else if (gx >= gy) begin
          gx <= gx - gy;
        end else begin
          gy <= gy - gx;
        end
      end
      ST_CHK: begin
        // A is 0 over 0: hand it back unchanged
        if (gcd_val == '0) begin
          qn <= '0;
          qd <= '0;
        end
      end
      ST_DIVN: begin
        if (div_stat.done) begin
          qn <= div_quotient;
        end
      end
      ST_DIVD: begin
        if (div_stat.done) begin
          qd <= div_quotient;
        end
      end
      default: begin
      end
    endcase
  end

  rau_divider #(
    .WIDTH (N)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (gcd_val),
    .quotient (div_quotient),
    .status   (div_stat)
  );

  // Result assembly: the quotients are exact, so restore the operand signs
  assign sum_add  = SW'(p0) + SW'(p1);
  assign sum_sub  = SW'(p0) - SW'(p1);
  assign simp_num = an[N-1] ? -$signed({1'b0, qn}) : $signed({1'b0, qn});
  assign simp_den = ad[N-1] ? -$signed({1'b0, qd}) : $signed({1'b0, qd});

  always_comb begin
    num_wide = '0;
    den_wide = '0;
    unique case (act) inside
      ACT_ADD: begin
        num_wide = WIDE'(sum_add);
        den_wide = WIDE'(p2);
      end
      ACT_SUB: begin
        num_wide = WIDE'(sum_sub);
        den_wide = WIDE'(p2);
      end
      ACT_MUL, ACT_DIV: begin
        num_wide = WIDE'(p0);
        den_wide = WIDE'(p2);
      end
      ACT_SIMP: begin
        num_wide = WIDE'(simp_num);
        den_wide = WIDE'(simp_den);
      end
      default: begin
        num_wide = '0;
        den_wide = '0;
      end
    endcase
  end

  // Output register: load when free, drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_free) begin
      res_num  <= num_wide[RES_NUM_W-1:0];
      res_den  <= den_wide[RES_DEN_W-1:0];
      zero_den <= (den_wide[RES_DEN_W-1:0] == '0);
    end
  end

  // Checks
  a_load_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_OUT)
    else $error("result presented without passing the output state");

  a_div_no_restart: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_stat.busy)
    else $error("divider restarted while busy");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != ST_IDLE)
    else $error("accepted transaction did not start the sequencer");

  a_zero_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> zero_den == (res_den == '0))
    else $error("zero_den disagrees with res_den");

endmodule

// File: hdl/rau_divider.sv
// ----------------------------------------------------------------------------
// rau_divider: iterative restoring divider
// Unsigned WIDTH-bit quotient, one quotient bit per cycle; done pulses when
// the quotient is final.
// ----------------------------------------------------------------------------
module rau_divider
  import rau_pkg::*;
#(
  parameter int WIDTH = OPERAND_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WIDTH-1:0] dividend,
  input  logic [WIDTH-1:0] divisor,
  output logic [WIDTH-1:0] quotient,
  output div_status_t      status
);

  localparam int CNT_W = $clog2(WIDTH + 1);

  logic [WIDTH-1:0] rem;
  logic [WIDTH-1:0] quo;
  logic [WIDTH-1:0] dvs;
  logic [CNT_W-1:0] count;
  logic             busy;
  logic             done;
  logic [WIDTH:0]   shifted;
  logic [WIDTH:0]   diff;

  assign shifted = {rem, quo[WIDTH-1]};
  assign diff    = shifted - {1'b0, dvs};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CNT_W'(WIDTH);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath: shift in one dividend bit, subtract when it fits
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      if (!diff[WIDTH]) begin
        rem <= diff[WIDTH-1:0];
      end else begin
        rem <= shifted[WIDTH-1:0];
      end
      quo <= {quo[WIDTH-2:0], ~diff[WIDTH]};
    end
  end

  assign quotient    = quo;
  assign status.busy = busy;
  assign status.done = done;

endmodule

// File: sim/tb_rational_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// tb_rational_arithmetic_unit: self-checking bench for the fraction unit
// Drives add, subtract, multiply, divide, simplify and the unused action
// codes, predicts every result from the operands, and compares each result
// transaction against the oldest prediction under varied input and output
// pacing, including a long output hold that backs the unit up.
// ----------------------------------------------------------------------------
module tb_rational_arithmetic_unit;
  import rau_pkg::*;

  localparam int OPW = OPERAND_BITS_DEF;

  // Action codes the unit has no name for; they must give 0 over 0.
  localparam logic [ACTION_W-1:0] ACT_BAD_LO  = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_BAD_MID = 3'd6;
  localparam logic [ACTION_W-1:0] ACT_BAD_HI  = 3'd7;

  localparam int PHASE_ITEMS    = 175;
  localparam int PRESSURE_ITEMS = 30;
  localparam int LONG_HOLD      = 300;
  localparam int DRAIN_LIMIT    = 5000;
  // Simplify is the slowest action; let a little more pass at the end.
  localparam int TAIL_CYCLES    = 120;
  localparam int REPORT_LIMIT   = 10;

  typedef logic signed [OPW-1:0] operand_t;

  typedef struct {
    logic [ACTION_W-1:0] act;
    operand_t            an, ad, bn, bd;
  } request_t;

  typedef struct {
    request_t                    req;
    logic signed [RES_NUM_W-1:0] num;
    logic signed [RES_DEN_W-1:0] den;
    logic                        zero;
  } fraction_t;

  // --------------------------------------------------------------------------
  // Scoreboard: predict on input acceptance, compare on output acceptance.
  // --------------------------------------------------------------------------
  class fraction_scoreboard;
    fraction_t outstanding[$];
    int        mismatches = 0;
    int        checked    = 0;
    int        per_action[8];

    // Cross products for the arithmetic actions, Euclid on the magnitudes
    // for simplify; everything is wide enough here that nothing overflows.
    function fraction_t combine(request_t r);
      fraction_t f;
      longint    an, ad, bn, bd, n, d, x, y, t;
      an = r.an;
      ad = r.ad;
      bn = r.bn;
      bd = r.bd;
      n  = 0;
      d  = 0;
      case (r.act)
        ACT_ADD: begin
          n = an * bd + ad * bn;
          d = ad * bd;
        end
        ACT_SUB: begin
          n = an * bd - ad * bn;
          d = ad * bd;
        end
        ACT_MUL: begin
          n = an * bn;
          d = ad * bd;
        end
        ACT_DIV: begin
          n = an * bd;
          d = ad * bn;
        end
        ACT_SIMP: begin
          x = (an < 0) ? -an : an;
          y = (ad < 0) ? -ad : ad;
          while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
          end
          // 0 over 0 has no divisor; pass A through untouched
          if (x == 0) begin
            n = an;
            d = ad;
          end else begin
            n = an / x;
            d = ad / x;
          end
        end
        default: ;
      endcase
      f.req  = r;
      f.num  = n[RES_NUM_W-1:0];
      f.den  = d[RES_DEN_W-1:0];
      f.zero = (d[RES_DEN_W-1:0] == '0);
      return f;
    endfunction

    function void note_input(request_t r);
      per_action[r.act]++;
      outstanding.push_back(combine(r));
    endfunction

    function void check_result(logic signed [RES_NUM_W-1:0] num,
                               logic signed [RES_DEN_W-1:0] den, logic zero);
      fraction_t want;
      if (outstanding.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("ERROR: result %0d/%0d zero_den=%0b with nothing outstanding",
                   num, den, zero);
        return;
      end
      want = outstanding.pop_front();
      checked++;
      if (num !== want.num || den !== want.den || zero !== want.zero) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("ERROR: action %0d A=%0d/%0d B=%0d/%0d", want.req.act, want.req.an,
                   want.req.ad, want.req.bn, want.req.bd);
          $display("       expected %0d/%0d zero_den=%0b, got %0d/%0d zero_den=%0b",
                   want.num, want.den, want.zero, num, den, zero);
        end
      end
    endfunction

    function int pending();
      return outstanding.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals: every input starts at a known value.
  // --------------------------------------------------------------------------
  logic                        clk;
  logic                        rst       = 1'b1;
  logic                        in_valid  = 1'b0;
  logic                        in_stall;
  logic [ACTION_W-1:0]         action    = ACT_ADD;
  operand_t                    a_num     = '0;
  operand_t                    a_den     = '0;
  operand_t                    b_num     = '0;
  operand_t                    b_den     = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic signed [RES_NUM_W-1:0] res_num;
  logic signed [RES_DEN_W-1:0] res_den;
  logic                        zero_den;

  int   idle_pct   = 0;      // sender: chance per cycle of leaving a gap
  int   stall_pct  = 0;      // receiver: chance per cycle of stalling
  logic hold_req   = 1'b0;   // raised once by the main sequence for the long hold
  logic hold_taken = 1'b0;   // the receiver has started that hold
  int   hold_left  = 0;

  fraction_scoreboard sb = new();

  rational_arithmetic_unit #(
    .OPERAND_BITS(OPW)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .action   (action),
    .a_num    (a_num),
    .a_den    (a_den),
    .b_num    (b_num),
    .b_den    (b_den),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .res_num  (res_num),
    .res_den  (res_den),
    .zero_den (zero_den)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop in case the unit hangs.
  initial begin
    #8000000;
    $display("Verification failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Monitors: sample both channels at the edge, before anything updates.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall)
      sb.note_input(request_t'{action, a_num, a_den, b_num, b_den});
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result(res_num, res_den, zero_den);
  end

  // --------------------------------------------------------------------------
  // Receiver: random stall, or a long hold counted down here when asked for.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_req && !hold_taken) begin
      hold_left = LONG_HOLD;
      hold_taken <= 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic request_t make_item(logic [ACTION_W-1:0] act, int an, int ad,
                                         int bn, int bd);
    request_t r;
    r.act = act;
    r.an  = operand_t'(an);
    r.ad  = operand_t'(ad);
    r.bn  = operand_t'(bn);
    r.bd  = operand_t'(bd);
    return r;
  endfunction

  // Mostly full-range values, with corners and small numbers mixed in.
  function automatic operand_t random_operand();
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(4))
          0:       return operand_t'(-32768);
          1:       return operand_t'(32767);
          2:       return operand_t'(0);
          3:       return operand_t'(1);
          default: return operand_t'(-1);
        endcase
      end
      1, 2:    return operand_t'(int'($urandom_range(40)) - 20);
      default: return operand_t'($urandom);
    endcase
  endfunction

  function automatic request_t random_item();
    request_t r;
    int       k;
    r.an = random_operand();
    r.ad = random_operand();
    r.bn = random_operand();
    r.bd = random_operand();
    if ($urandom_range(99) < 6)
      r.act = ACTION_W'($urandom_range(ACT_BAD_HI, ACT_BAD_LO));
    else
      r.act = ACTION_W'($urandom_range(ACT_SIMP, ACT_ADD));
    // Give simplify a common factor half the time so it has work to do.
    if (r.act == ACT_SIMP && $urandom_range(1) == 1) begin
      k    = $urandom_range(200, 1);
      r.an = operand_t'(k * (int'($urandom_range(160)) - 80));
      r.ad = operand_t'(k * (int'($urandom_range(160)) - 80));
    end
    return r;
  endfunction

  // Call at a rising edge. Optionally idle first, then present the
  // transaction and hold it until the unit takes it.
  task automatic send_item(request_t r);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct)
      gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    action   <= r.act;
    a_num    <= r.an;
    a_den    <= r.ad;
    b_num    <= r.bn;
    b_den    <= r.bd;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid and wait for every outstanding result, with a bound.
  task automatic settle();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    do begin
      @(posedge clk);
      waited++;
    end while (sb.pending() != 0 && waited < DRAIN_LIMIT);
  endtask

  task automatic run_directed();
    // arithmetic extremes and zero denominators
    send_item(make_item(ACT_ADD, 32767, 32767, 32767, 32767));
    send_item(make_item(ACT_ADD, -32768, -32768, -32768, -32768));
    send_item(make_item(ACT_ADD, 1, 0, 1, 5));
    send_item(make_item(ACT_SUB, -32768, 32767, 32767, -32768));
    send_item(make_item(ACT_SUB, 0, 1, 0, 1));
    send_item(make_item(ACT_MUL, -32768, -32768, -32768, -32768));
    send_item(make_item(ACT_MUL, 32767, 1, -32768, -1));
    send_item(make_item(ACT_DIV, 1, 2, 3, 4));
    send_item(make_item(ACT_DIV, 5, 7, 0, 3));
    send_item(make_item(ACT_DIV, -32768, 32767, 32767, -32768));
    // simplify: signs kept, zero parts, both zero, largest magnitudes
    send_item(make_item(ACT_SIMP, 12, 18, 7, -3));
    send_item(make_item(ACT_SIMP, -12, 18, 7, -3));
    send_item(make_item(ACT_SIMP, 12, -18, 7, -3));
    send_item(make_item(ACT_SIMP, 0, 0, 7, -3));
    send_item(make_item(ACT_SIMP, 0, 5, 7, -3));
    send_item(make_item(ACT_SIMP, 0, -32768, 7, -3));
    send_item(make_item(ACT_SIMP, 5, 0, 7, -3));
    send_item(make_item(ACT_SIMP, -5, 0, 7, -3));
    send_item(make_item(ACT_SIMP, -32768, -32768, 7, -3));
    send_item(make_item(ACT_SIMP, -32768, 32767, 7, -3));
    send_item(make_item(ACT_SIMP, 32767, 0, 7, -3));
    send_item(make_item(ACT_SIMP, 1, 1, 7, -3));
    // codes with no action behind them
    send_item(make_item(ACT_BAD_LO, 9, 4, -2, 3));
    send_item(make_item(ACT_BAD_MID, 9, 4, -2, 3));
    send_item(make_item(ACT_BAD_HI, 9, 4, -2, 3));
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  int idle_plan[4]  = '{0, 62, 0, 12};
  int stall_plan[4] = '{0, 0, 62, 12};

  initial begin
    int leftover;

    // Hold reset at the start, then release it once for good.
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    run_directed();
    settle();

    // Random traffic under each pacing mode: free running, sender gaps,
    // receiver stalls, then a little of both.
    for (int p = 0; p < 4; p++) begin
      idle_pct = idle_plan[p];
      stall_pct <= stall_plan[p];
      repeat (PHASE_ITEMS) send_item(random_item());
    end

    // Back the unit up: hold the output for a long stretch while the sender
    // keeps offering, so the output register fills and the input stalls.
    idle_pct = 0;
    stall_pct <= 0;
    hold_req <= 1'b1;
    repeat (PRESSURE_ITEMS) send_item(random_item());

    // Pause the sender until everything has come back, then resume briefly.
    settle();
    stall_pct <= 30;
    repeat (20) send_item(random_item());

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);

    leftover = sb.pending();
    if (leftover != 0)
      $display("ERROR: %0d expected results never arrived", leftover);
    if (sb.mismatches > REPORT_LIMIT)
      $display("%0d further mismatches not shown", sb.mismatches - REPORT_LIMIT);

    $display("Covered add %0d, sub %0d, mul %0d, div %0d, simplify %0d, unused codes %0d",
             sb.per_action[ACT_ADD], sb.per_action[ACT_SUB], sb.per_action[ACT_MUL],
             sb.per_action[ACT_DIV], sb.per_action[ACT_SIMP],
             sb.per_action[ACT_BAD_LO] + sb.per_action[ACT_BAD_MID] +
             sb.per_action[ACT_BAD_HI]);
    $display("%0d results compared across four pacing modes and a long output hold",
             sb.checked);

    if (sb.mismatches == 0 && leftover == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
